// ===== hdl/cllm_pkg.sv =====
// Shared types and codes for the circular linked list manager.
// Holds the command codes, the sequencer states and the result flag group.
// No dependencies; the top module and the list engine import this package.
`timescale 1ns / 1ps

package cllm_pkg;

  // Width of the command field on the input transaction.
  localparam int unsigned CMD_W = 3;

  // Command codes; the two remaining codes are rejected as errors.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT      = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_POP       = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_INS_AFTER = 3'd5
  } cmd_e;

  // Sequencer states of the list engine.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_CHK,
    ST_LINK_A,
    ST_LINK_B,
    ST_UNLINK,
    ST_SINGLE,
    ST_DONE
  } state_e;

  // Status flags returned with each result, lowest bit last.
  typedef struct packed {
    logic op_error;
    logic list_empty;
    logic popped_valid;
  } res_flags_t;

endpackage

// ===== hdl/circular_linked_list_manager.sv =====
// The block works on one transaction at a time; each link memory has a single read and a
// single write port, and the next input is taken once the result is registered.
// Reset: synchronous, active low; afterwards a clearing pass over all NODE_COUNT nodes
// makes every node self-linked, with in_tready low meanwhile. All lists start empty.
`timescale 1ns / 1ps

module circular_linked_list_manager
  import cllm_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int LIST_COUNT = 8,
  localparam int NODE_W = $clog2(NODE_COUNT),
  localparam int LIST_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1,
  localparam int IN_W   = CMD_W + LIST_W + 2 * NODE_W,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = NODE_W + 3,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // Fields from bit 0: command, list_id, node, start_node, zero padding.
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // Fields from bit 0: popped_node, popped_valid, list_empty, op_error, zero padding.
  output logic [OUT_TW-1:0] out_tdata
);

  logic              res_valid;
  logic              res_ready;
  logic [NODE_W-1:0] res_popped_node;
  res_flags_t        res_flags;

  logic              out_tvalid_r;
  logic [OUT_TW-1:0] out_tdata_r;

  // List engine.
  cllm_core #(
    .NODE_COUNT (NODE_COUNT),
    .LIST_COUNT (LIST_COUNT)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (in_tvalid),
    .req_ready       (in_tready),
    .req_command     (in_tdata[CMD_W-1:0]),
    .req_list_id     (in_tdata[CMD_W +: LIST_W]),
    .req_node        (in_tdata[CMD_W + LIST_W +: NODE_W]),
    .req_start_node  (in_tdata[CMD_W + LIST_W + NODE_W +: NODE_W]),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_popped_node (res_popped_node),
    .res_flags       (res_flags)
  );

  // Output register: takes a result whenever it is empty or being emptied.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= OUT_TW'({res_flags, res_popped_node});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hdl/cllm_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Used for the forward links, the backward links and the list heads.
// No dependencies.
`timescale 1ns / 1ps

module cllm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; a read in the cycle of a write returns the old data.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/cllm_core.sv =====
// List engine: sequencer, shared node comparator, the two link memories and the head memory.
// Depends on cllm_pkg for codes and states and on cllm_ram for storage.
// Takes one request at a time and hands back one result with its flags.
`timescale 1ns / 1ps

module cllm_core
  import cllm_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int LIST_COUNT = 8,
  localparam int NODE_W = $clog2(NODE_COUNT),
  localparam int LIST_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [CMD_W-1:0]  req_command,
  input  logic [LIST_W-1:0] req_list_id,
  input  logic [NODE_W-1:0] req_node,
  input  logic [NODE_W-1:0] req_start_node,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [NODE_W-1:0] res_popped_node,
  output res_flags_t        res_flags
);

  localparam int LIST_SPAN = 1 << LIST_W;

  state_e state_r, state_nxt;

  // Captured request and working registers.
  cmd_e              cmd_r;
  logic [LIST_W-1:0] lst_r;
  logic [NODE_W-1:0] node_r;
  logic [NODE_W-1:0] strt_r;
  logic [NODE_W-1:0] a_r;     // forward neighbour of the node being linked
  logic [NODE_W-1:0] b_r;     // backward neighbour of the node being linked
  logic [NODE_W-1:0] h_r;
  logic              eq_r;
  logic              err_r;
  logic              pop_r;
  logic [NODE_W-1:0] clr_cnt_r;
  logic [LIST_SPAN-1:0] present_r;

  // Memory ports.
  logic              nxt_we, prv_we, hd_we;
  logic [NODE_W-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, hd_wdata;
  logic [NODE_W-1:0] nxt_raddr, prv_raddr;
  logic [NODE_W-1:0] nxt_rdata, prv_rdata, hd_rdata;

  // Control strobes from the sequencer.
  logic pres_set, pres_clr, err_set;

  // Shared comparator.
  logic [NODE_W-1:0] cmp_a;
  logic              cmp_eq;

  logic node_bad, strt_bad, lst_bad, cmd_bad, bad_req;
  logic lst_present;
  logic clr_last;

  // Range and code checks on the captured request.
  assign node_bad = {1'b0, node_r} >= (NODE_W + 1)'(NODE_COUNT);
  assign strt_bad = {1'b0, strt_r} >= (NODE_W + 1)'(NODE_COUNT);
  assign lst_bad  = {1'b0, lst_r} >= (LIST_W + 1)'(LIST_COUNT);

  always_comb begin
    case (cmd_r) inside
      CMD_INIT, CMD_INS_FRONT, CMD_INS_BACK, CMD_POP, CMD_REMOVE: cmd_bad = 1'b0;
      CMD_INS_AFTER: cmd_bad = strt_bad;
      default:       cmd_bad = 1'b1;
    endcase
  end

  assign bad_req     = lst_bad || node_bad || cmd_bad;
  assign lst_present = present_r[lst_r];
  assign clr_last    = (clr_cnt_r == NODE_W'(NODE_COUNT - 1));

  // Read addresses: the node (or start node) first, then the head's predecessor.
  assign nxt_raddr = (cmd_r == CMD_INS_AFTER) ? strt_r : node_r;
  assign prv_raddr = (state_r == ST_RD1) ? hd_rdata : node_r;

  // The one equality comparator, its first operand chosen by state.
  always_comb begin
    cmp_a = node_r;
    if (state_r == ST_RD1) begin
      cmp_a = (cmd_r == CMD_INS_AFTER) ? strt_r : nxt_rdata;
    end else if (state_r == ST_CHK) begin
      cmp_a = (cmd_r == CMD_REMOVE) ? h_r : b_r;
    end
  end

  assign cmp_eq = (cmp_a == node_r);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and memory write strobes.
  always_comb begin
    state_nxt = state_r;
    nxt_we    = 1'b0;
    nxt_waddr = node_r;
    nxt_wdata = node_r;
    prv_we    = 1'b0;
    prv_waddr = node_r;
    prv_wdata = node_r;
    hd_we     = 1'b0;
    hd_wdata  = node_r;
    pres_set  = 1'b0;
    pres_clr  = 1'b0;
    err_set   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_waddr = clr_cnt_r;
        nxt_wdata = clr_cnt_r;
        prv_waddr = clr_cnt_r;
        prv_wdata = clr_cnt_r;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        if (bad_req) begin
          err_set   = 1'b1;
          state_nxt = ST_DONE;
        end else if (cmd_r == CMD_INIT) begin
          nxt_we    = 1'b1;
          prv_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        case (cmd_r)
          CMD_POP: begin
            state_nxt = lst_present ? ST_RD0 : ST_DONE;
          end
          CMD_REMOVE: begin
            if (!lst_present) begin
              err_set   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_CHK;
            end
          end
          CMD_INS_AFTER: begin
            if (!lst_present || cmp_eq) begin
              err_set   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_LINK_A;
            end
          end
          default: begin
            state_nxt = ST_CHK;
          end
        endcase
      end
      ST_CHK: begin
        if (cmd_r == CMD_REMOVE) begin
          if (eq_r) begin
            // A self-linked node may only leave as the sole head.
            if (!cmp_eq) begin
              err_set   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              pres_clr  = 1'b1;
              state_nxt = ST_SINGLE;
            end
          end else begin
            if (cmp_eq) begin
              hd_we    = 1'b1;
              hd_wdata = a_r;
            end
            state_nxt = ST_UNLINK;
          end
        end else begin
          // Insert at front or back: the node must be self-linked.
          if (!(eq_r && cmp_eq)) begin
            err_set   = 1'b1;
            state_nxt = ST_DONE;
          end else if (!lst_present) begin
            hd_we     = 1'b1;
            pres_set  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LINK_A;
          end
        end
      end
      ST_LINK_A: begin
        nxt_we    = 1'b1;
        nxt_wdata = a_r;
        prv_we    = 1'b1;
        prv_wdata = b_r;
        state_nxt = ST_LINK_B;
      end
      ST_LINK_B: begin
        nxt_we    = 1'b1;
        nxt_waddr = b_r;
        prv_we    = 1'b1;
        prv_waddr = a_r;
        hd_we     = (cmd_r == CMD_INS_FRONT);
        state_nxt = ST_DONE;
      end
      ST_UNLINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = b_r;
        nxt_wdata = a_r;
        prv_we    = 1'b1;
        prv_waddr = a_r;
        prv_wdata = b_r;
        state_nxt = ST_SINGLE;
      end
      ST_SINGLE: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers: clearing counter, list presence, error and pop marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      present_r <= '0;
      err_r     <= 1'b0;
      pop_r     <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (pres_set) begin
        present_r[lst_r] <= 1'b1;
      end else if (pres_clr) begin
        present_r[lst_r] <= 1'b0;
      end
      if (state_r == ST_IDLE && req_valid) begin
        err_r <= 1'b0;
        pop_r <= 1'b0;
      end else begin
        if (err_set) begin
          err_r <= 1'b1;
        end
        if (state_r == ST_RD1 && cmd_r == CMD_POP) begin
          pop_r <= lst_present;
        end
      end
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          cmd_r  <= cmd_e'(req_command);
          lst_r  <= req_list_id;
          node_r <= req_node;
          strt_r <= req_start_node;
        end
      end
      ST_RD1: begin
        eq_r <= cmp_eq;
        h_r  <= hd_rdata;
        case (cmd_r)
          CMD_POP: begin
            // Pop becomes a removal of the current head.
            node_r <= hd_rdata;
            cmd_r  <= CMD_REMOVE;
          end
          CMD_INS_AFTER: begin
            a_r <= nxt_rdata;
            b_r <= strt_r;
          end
          CMD_REMOVE: begin
            a_r <= nxt_rdata;
            b_r <= prv_rdata;
          end
          default: begin
            a_r <= hd_rdata;
            b_r <= prv_rdata;
          end
        endcase
      end
      ST_CHK: begin
        if (cmd_r != CMD_REMOVE) begin
          b_r <= prv_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Link and head storage.
  cllm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  cllm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  cllm_ram #(.WIDTH(NODE_W), .DEPTH(LIST_COUNT)) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (lst_r),
    .wdata (hd_wdata),
    .raddr (lst_r),
    .rdata (hd_rdata)
  );

  // Result of the finished transaction.
  assign req_ready              = (state_r == ST_IDLE);
  assign res_valid              = (state_r == ST_DONE);
  assign res_popped_node        = pop_r ? node_r : '0;
  assign res_flags.popped_valid = pop_r;
  assign res_flags.op_error     = err_r;
  assign res_flags.list_empty   = lst_bad ? 1'b1 : !lst_present;

  // A successful pop never reports an error.
  a_pop_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_flags.popped_valid |-> !res_flags.op_error)
    else $error("pop reported together with an error");

  // An accepted request always starts with the first read state.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready |=> state_r == ST_RD0)
    else $error("accepted request did not start the read sequence");

  // Nothing is written to the link or head memories while waiting for work or holding a result.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE || state_r == ST_DONE |-> !nxt_we && !prv_we && !hd_we)
    else $error("memory written outside an operation");

  // A failed check leaves the presence bits untouched.
  a_err_keeps_present: assert property (@(posedge clk) disable iff (!rst_n)
    err_set |=> $stable(present_r))
    else $error("presence changed on a failed operation");

endmodule
